// ----- src/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg - timer wheel shared definitions
// Wheel geometry, link encodings, item and result codes, sequencer
// commands and the command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package htw_pkg;

    // wheel geometry
    localparam int NEAR_BITS    = 8;
    localparam int LEVEL_BITS   = 6;
    localparam int OUTER_LEVELS = 4;
    localparam int MAX_TIMERS   = 64;
    localparam int NEAR_SIZE    = 1 << NEAR_BITS;
    localparam int LEVEL_SIZE   = 1 << LEVEL_BITS;
    localparam int NSLOTS       = NEAR_SIZE + OUTER_LEVELS * LEVEL_SIZE;
    localparam int SLOT_W       = $clog2(NSLOTS);
    localparam int ID_W         = $clog2(MAX_TIMERS);
    localparam int LINK_W       = ID_W + 1;
    localparam int LVL_W        = (OUTER_LEVELS > 1) ? $clog2(OUTER_LEVELS) : 1;

    // list terminator and far clamp
    localparam logic [LINK_W-1:0] NIL        = LINK_W'(MAX_TIMERS);
    localparam logic [63:0]       CLAMP_SPAN = 64'h0000_0000_ffff_ffff;

    // item kinds
    localparam logic [1:0] K_ADD  = 2'd0;
    localparam logic [1:0] K_STOP = 2'd1;
    localparam logic [1:0] K_TICK = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FIRED = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_INACT = 2'd3;

    // sequencer steps, also the datapath command
    localparam int OP_W = 5;
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_IDLE       = 5'd0;
    localparam op_t OP_CLR        = 5'd1;
    localparam op_t OP_DISP       = 5'd2;
    localparam op_t OP_UL_RD      = 5'd3;
    localparam op_t OP_UL_SRD     = 5'd4;
    localparam op_t OP_UL_WR      = 5'd5;
    localparam op_t OP_F_D        = 5'd6;
    localparam op_t OP_F_S        = 5'd7;
    localparam op_t OP_F_RD       = 5'd8;
    localparam op_t OP_F_WR       = 5'd9;
    localparam op_t OP_F_LNK      = 5'd10;
    localparam op_t OP_T_START    = 5'd11;
    localparam op_t OP_C_RD       = 5'd12;
    localparam op_t OP_C_DET      = 5'd13;
    localparam op_t OP_C_NRD      = 5'd14;
    localparam op_t OP_C_NLD      = 5'd15;
    localparam op_t OP_ADV        = 5'd16;
    localparam op_t OP_C_NEXT     = 5'd17;
    localparam op_t OP_N_RD       = 5'd18;
    localparam op_t OP_N_DET      = 5'd19;
    localparam op_t OP_N_NRD      = 5'd20;
    localparam op_t OP_N_NLD      = 5'd21;
    localparam op_t OP_DEACT      = 5'd22;
    localparam op_t OP_EMIT_DONE  = 5'd23;
    localparam op_t OP_EMIT_INACT = 5'd24;
    localparam op_t OP_EMIT_NONE  = 5'd25;
    localparam op_t OP_EMIT_FIRE  = 5'd26;

    typedef struct packed {
        op_t  op;
        logic load;
    } htw_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       active;
        logic       late;
        logic       ct_low_zero;
        logic       head_nil;
        logic       nx_nil;
        logic       idx_zero;
        logic       lvl_last;
        logic       per_rd;
        logic       out_free;
        logic       clr_last;
    } htw_sts_t;

endpackage

// ----- src/htw_if.sv -----
// ----------------------------------------------------------------------------
// htw_if - timer wheel channels
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
interface htw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  timer_id;
    logic [63:0] expire_time;
    logic [31:0] interval;
    logic        periodic;
    logic [63:0] now;

    modport source (output valid, kind, timer_id, expire_time, interval, periodic, now,
                    input ready);
    modport sink (input valid, kind, timer_id, expire_time, interval, periodic, now,
                  output ready);
endinterface

interface htw_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] fired_id;
    logic       last;

    modport source (output valid, status, fired_id, last, input ready);
    modport sink (input valid, status, fired_id, last, output ready);
endinterface

// ----- src/hierarchical_timer_wheel.sv -----
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel - cascading timing wheel
// 256 near slots and four 64-slot outer levels, each slot a FIFO list of
// timer ids; add, stop and tick items, one result per fired timer.
//
//   channel   dir   transfer when        payload
//   item_in   in    valid && ready       kind, timer_id, expire_time,
//                                        interval, periodic, now
//   result    out   valid && ready       status, fired_id, last
//   cfg       in    cfg_we               cfg_wdata -> check time
//
// Only one item is in work at a time: item_in is ready only while the
// sequencer is idle, which it reaches again once the last result of the
// previous item is in the result register. After reset a clearing pass
// empties all 512 slots of the slot memory; items wait until it ends. A
// stalled result holds the sequencer in place.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel (
    input  logic       clk,
    input  logic       rst_n,
    htw_in_if.sink     item_in,
    htw_out_if.source  result,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata
);

    htw_pkg::htw_cmd_t cmd;
    htw_pkg::htw_sts_t sts;

    // sequencer
    htw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    htw_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (item_in.kind),
        .timer_id    (item_in.timer_id),
        .expire_time (item_in.expire_time),
        .interval    (item_in.interval),
        .periodic    (item_in.periodic),
        .now         (item_in.now),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .status      (result.status),
        .fired_id    (result.fired_id),
        .last        (result.last)
    );

endmodule

// ----- src/htw_ctrl.sv -----
// ----------------------------------------------------------------------------
// htw_ctrl - timer wheel sequencer
// Steps through clear, add, stop, cascade and fire sequences and drives the
// datapath one command per cycle.
// ----------------------------------------------------------------------------
module htw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  htw_pkg::htw_sts_t sts,
    output htw_pkg::htw_cmd_t cmd
);

    logic [htw_pkg::OP_W-1:0] state_reg;
    logic [htw_pkg::OP_W-1:0] state_next;
    logic                     near_reg;
    logic                     near_next;

    // state and phase registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htw_pkg::OP_CLR;
            near_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            near_reg  <= near_next;
        end
    end

    // phase flag: set while firing the near slot
    always_comb
    begin
        near_next = near_reg;
        if (state_reg == htw_pkg::OP_N_RD)
            near_next = 1'b1;
        else if (state_reg == htw_pkg::OP_IDLE)
            near_next = 1'b0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            htw_pkg::OP_CLR:
                if (sts.clr_last) state_next = htw_pkg::OP_IDLE;
            htw_pkg::OP_IDLE:
                if (in_valid) state_next = htw_pkg::OP_DISP;
            htw_pkg::OP_DISP:
            begin
                case (sts.kind)
                    htw_pkg::K_ADD:
                        state_next = sts.active ? htw_pkg::OP_UL_RD : htw_pkg::OP_F_D;
                    htw_pkg::K_STOP:
                        state_next = sts.active ? htw_pkg::OP_UL_RD : htw_pkg::OP_EMIT_INACT;
                    htw_pkg::K_TICK:
                        state_next = sts.late ? htw_pkg::OP_EMIT_NONE : htw_pkg::OP_T_START;
                    default:
                        state_next = htw_pkg::OP_IDLE;
                endcase
            end
            htw_pkg::OP_UL_RD:   state_next = htw_pkg::OP_UL_SRD;
            htw_pkg::OP_UL_SRD:  state_next = htw_pkg::OP_UL_WR;
            htw_pkg::OP_UL_WR:
                state_next = (sts.kind == htw_pkg::K_ADD) ? htw_pkg::OP_F_D
                                                          : htw_pkg::OP_EMIT_DONE;
            htw_pkg::OP_F_D:     state_next = htw_pkg::OP_F_S;
            htw_pkg::OP_F_S:     state_next = htw_pkg::OP_F_RD;
            htw_pkg::OP_F_RD:    state_next = htw_pkg::OP_F_WR;
            htw_pkg::OP_F_WR:    state_next = htw_pkg::OP_F_LNK;
            htw_pkg::OP_F_LNK:
            begin
                if (sts.kind == htw_pkg::K_ADD)
                    state_next = htw_pkg::OP_EMIT_DONE;
                else if (near_reg)
                    state_next = htw_pkg::OP_EMIT_FIRE;
                else
                    state_next = htw_pkg::OP_ADV;
            end
            htw_pkg::OP_T_START:
                state_next = sts.ct_low_zero ? htw_pkg::OP_C_RD : htw_pkg::OP_N_RD;
            htw_pkg::OP_C_RD:    state_next = htw_pkg::OP_C_DET;
            htw_pkg::OP_C_DET:
                state_next = sts.head_nil ? htw_pkg::OP_C_NEXT : htw_pkg::OP_C_NRD;
            htw_pkg::OP_C_NRD:   state_next = htw_pkg::OP_C_NLD;
            htw_pkg::OP_C_NLD:   state_next = htw_pkg::OP_F_D;
            htw_pkg::OP_ADV:
                state_next = sts.nx_nil ? htw_pkg::OP_C_NEXT : htw_pkg::OP_C_NRD;
            htw_pkg::OP_C_NEXT:
                state_next = (sts.idx_zero && !sts.lvl_last) ? htw_pkg::OP_C_RD
                                                             : htw_pkg::OP_N_RD;
            htw_pkg::OP_N_RD:    state_next = htw_pkg::OP_N_DET;
            htw_pkg::OP_N_DET:
                state_next = sts.head_nil ? htw_pkg::OP_EMIT_NONE : htw_pkg::OP_N_NRD;
            htw_pkg::OP_N_NRD:   state_next = htw_pkg::OP_N_NLD;
            htw_pkg::OP_N_NLD:
                state_next = sts.per_rd ? htw_pkg::OP_F_D : htw_pkg::OP_DEACT;
            htw_pkg::OP_DEACT:   state_next = htw_pkg::OP_EMIT_FIRE;
            htw_pkg::OP_EMIT_DONE, htw_pkg::OP_EMIT_INACT, htw_pkg::OP_EMIT_NONE:
                if (sts.out_free) state_next = htw_pkg::OP_IDLE;
            htw_pkg::OP_EMIT_FIRE:
                if (sts.out_free)
                    state_next = sts.nx_nil ? htw_pkg::OP_IDLE : htw_pkg::OP_N_NRD;
            default:
                state_next = htw_pkg::OP_IDLE;
        endcase
    end

    // command to the datapath
    assign in_ready = (state_reg == htw_pkg::OP_IDLE);
    assign cmd.op   = state_reg;
    assign cmd.load = (state_reg == htw_pkg::OP_IDLE) && in_valid;

endmodule

// ----- src/htw_dp.sv -----
// ----------------------------------------------------------------------------
// htw_dp - timer wheel datapath
// Slot and timer memories, check time, link registers, slot selection and
// the result register.
// ----------------------------------------------------------------------------
module htw_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  htw_pkg::htw_cmd_t cmd,
    output htw_pkg::htw_sts_t sts,
    input  logic [1:0]        kind,
    input  logic [5:0]        timer_id,
    input  logic [63:0]       expire_time,
    input  logic [31:0]       interval,
    input  logic              periodic,
    input  logic [63:0]       now,
    input  logic              cfg_we,
    input  logic [63:0]       cfg_wdata,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [5:0]        fired_id,
    output logic              last
);

    localparam int LW = htw_pkg::LINK_W;
    localparam int IW = htw_pkg::ID_W;
    localparam int SW = htw_pkg::SLOT_W;

    // memories
    logic [2*LW-1:0] slot_mem [htw_pkg::NSLOTS];
    logic [LW-1:0]   next_mem [htw_pkg::MAX_TIMERS];
    logic [LW-1:0]   prev_mem [htw_pkg::MAX_TIMERS];
    logic [SW-1:0]   sid_mem  [htw_pkg::MAX_TIMERS];
    logic [63:0]     exp_mem  [htw_pkg::MAX_TIMERS];
    logic [32:0]     rel_mem  [htw_pkg::MAX_TIMERS];

    logic [2*LW-1:0] slot_q;
    logic [LW-1:0]   next_q;
    logic [LW-1:0]   prev_q;
    logic [SW-1:0]   sid_q;
    logic [63:0]     exp_q;
    logic [32:0]     rel_q;

    logic            slot_we;
    logic [SW-1:0]   slot_wa;
    logic [SW-1:0]   slot_ra;
    logic [2*LW-1:0] slot_wd;
    logic            next_we;
    logic [IW-1:0]   next_wa;
    logic [LW-1:0]   next_wd;
    logic            prev_we;
    logic [IW-1:0]   prev_wa;
    logic [LW-1:0]   prev_wd;
    logic            sid_we;
    logic            exp_we;
    logic [IW-1:0]   exp_wa;
    logic [63:0]     exp_wd;
    logic            rel_we;

    // control registers
    logic [63:0]                    ct_reg;
    logic [63:0]                    ct_next;
    logic [htw_pkg::MAX_TIMERS-1:0] active_reg;
    logic [htw_pkg::MAX_TIMERS-1:0] active_next;
    logic [SW-1:0]                  clr_cnt_reg;
    logic [SW-1:0]                  clr_cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // working registers
    logic [1:0]                   kind_reg;
    logic [IW-1:0]                id_reg;
    logic [63:0]                  now_reg;
    logic [63:0]                  exp_reg;
    logic [63:0]                  d_reg;
    logic [LW-1:0]                cur_reg;
    logic [LW-1:0]                nx_reg;
    logic [LW-1:0]                p_reg;
    logic [LW-1:0]                n_reg;
    logic [LW-1:0]                t_reg;
    logic [SW-1:0]                s_reg;
    logic [htw_pkg::LEVEL_BITS-1:0] idx_reg;
    logic [htw_pkg::LVL_W-1:0]    lvl_reg;
    logic [1:0]                   status_reg;
    logic [5:0]                   fired_id_reg;
    logic                         last_reg;

    logic [LW-1:0]                  slot_head;
    logic [LW-1:0]                  slot_tail;
    logic [IW-1:0]                  cur_a;
    logic [htw_pkg::LEVEL_BITS-1:0] c_idx;
    logic [SW-1:0]                  c_slot;
    logic [SW-1:0]                  near_slot;
    logic [SW-1:0]                  pick;
    logic [63:0]                    reload_exp;
    logic                           emit;
    logic                           load_add;

    // slot index of an outer level for time t
    function automatic logic [SW-1:0] level_slot(input int lvl, input logic [63:0] t);
        logic [63:0] sh;
        sh = t >> (htw_pkg::NEAR_BITS + lvl * htw_pkg::LEVEL_BITS);
        return SW'(htw_pkg::NEAR_SIZE + lvl * htw_pkg::LEVEL_SIZE)
             + SW'(sh[htw_pkg::LEVEL_BITS-1:0]);
    endfunction

    // slot choice from distance d, expiry e and check time c
    function automatic logic [SW-1:0] pick_slot(input logic [63:0] d, input logic [63:0] e,
                                                input logic [63:0] c);
        logic [63:0] ce;
        logic [SW-1:0] s;
        logic found;
        ce    = c + htw_pkg::CLAMP_SPAN;
        s     = '0;
        found = 1'b0;
        if ((d >> htw_pkg::NEAR_BITS) == 64'd0)
        begin
            s     = SW'(e[htw_pkg::NEAR_BITS-1:0]);
            found = 1'b1;
        end
        for (int l = 0; l < htw_pkg::OUTER_LEVELS - 1; l++)
        begin
            if (!found && (d >> (htw_pkg::NEAR_BITS + (l + 1) * htw_pkg::LEVEL_BITS)) == 64'd0)
            begin
                s     = level_slot(l, e);
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (d[63])
                s = SW'(c[htw_pkg::NEAR_BITS-1:0]);
            else if (d > htw_pkg::CLAMP_SPAN)
                s = level_slot(htw_pkg::OUTER_LEVELS - 1, ce);
            else
                s = level_slot(htw_pkg::OUTER_LEVELS - 1, e);
        end
        return s;
    endfunction

    assign slot_head = slot_q[2*LW-1:LW];
    assign slot_tail = slot_q[LW-1:0];
    assign cur_a     = cur_reg[IW-1:0];
    assign near_slot = SW'(ct_reg[htw_pkg::NEAR_BITS-1:0]);
    assign pick      = pick_slot(d_reg, exp_reg, ct_reg);
    assign reload_exp = now_reg + {32'd0, rel_q[31:0]};
    assign emit      = (!out_valid_reg || out_ready)
                    && (cmd.op == htw_pkg::OP_EMIT_DONE || cmd.op == htw_pkg::OP_EMIT_INACT
                     || cmd.op == htw_pkg::OP_EMIT_NONE || cmd.op == htw_pkg::OP_EMIT_FIRE);
    assign load_add  = cmd.load && (kind == htw_pkg::K_ADD);

    // level index picked by check time for the level being cascaded
    always_comb
    begin
        logic [63:0] sh;
        sh     = ct_reg >> (htw_pkg::NEAR_BITS + int'(lvl_reg) * htw_pkg::LEVEL_BITS);
        c_idx  = sh[htw_pkg::LEVEL_BITS-1:0];
        c_slot = SW'(htw_pkg::NEAR_SIZE + int'(lvl_reg) * htw_pkg::LEVEL_SIZE) + SW'(c_idx);
    end

    // slot memory port selection
    always_comb
    begin
        slot_we = 1'b0;
        slot_wa = s_reg;
        slot_wd = {htw_pkg::NIL, htw_pkg::NIL};
        unique case (cmd.op)
            htw_pkg::OP_CLR:
            begin
                slot_we = 1'b1;
                slot_wa = clr_cnt_reg;
            end
            htw_pkg::OP_UL_WR:
            begin
                slot_we = 1'b1;
                slot_wd = {(p_reg == htw_pkg::NIL) ? n_reg : slot_head,
                           (n_reg == htw_pkg::NIL) ? p_reg : slot_tail};
            end
            htw_pkg::OP_F_WR:
            begin
                slot_we = 1'b1;
                slot_wd = {(slot_tail == htw_pkg::NIL) ? cur_reg : slot_head, cur_reg};
            end
            htw_pkg::OP_C_DET, htw_pkg::OP_N_DET:
                slot_we = 1'b1;
            default:
                slot_we = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            htw_pkg::OP_UL_SRD: slot_ra = sid_q;
            htw_pkg::OP_C_RD:   slot_ra = c_slot;
            htw_pkg::OP_N_RD:   slot_ra = near_slot;
            default:            slot_ra = s_reg;
        endcase
    end

    // link memory port selection
    always_comb
    begin
        next_we = 1'b0;
        next_wa = cur_a;
        next_wd = htw_pkg::NIL;
        prev_we = 1'b0;
        prev_wa = cur_a;
        prev_wd = slot_tail;
        case (cmd.op)
            htw_pkg::OP_UL_WR:
            begin
                next_we = (p_reg != htw_pkg::NIL);
                next_wa = p_reg[IW-1:0];
                next_wd = n_reg;
                prev_we = (n_reg != htw_pkg::NIL);
                prev_wa = n_reg[IW-1:0];
                prev_wd = p_reg;
            end
            htw_pkg::OP_F_WR:
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            htw_pkg::OP_F_LNK:
            begin
                next_we = (t_reg != htw_pkg::NIL);
                next_wa = t_reg[IW-1:0];
                next_wd = cur_reg;
            end
            default:
            begin
                next_we = 1'b0;
                prev_we = 1'b0;
            end
        endcase
    end

    // timer record port selection
    always_comb
    begin
        sid_we = (cmd.op == htw_pkg::OP_F_WR);
        rel_we = load_add;
        exp_we = 1'b0;
        exp_wa = cur_a;
        exp_wd = reload_exp;
        if (load_add)
        begin
            exp_we = 1'b1;
            exp_wa = timer_id;
            exp_wd = expire_time;
        end
        else if (cmd.op == htw_pkg::OP_N_NLD && rel_q[32])
            exp_we = 1'b1;
    end

    // memories, registered read
    always_ff @(posedge clk)
    begin
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        slot_q <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk)
    begin
        if (next_we) next_mem[next_wa] <= next_wd;
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        if (sid_we) sid_mem[cur_a] <= s_reg;
        if (exp_we) exp_mem[exp_wa] <= exp_wd;
        if (rel_we) rel_mem[timer_id] <= {periodic, interval};
        next_q <= next_mem[cur_a];
        prev_q <= prev_mem[cur_a];
        sid_q  <= sid_mem[cur_a];
        exp_q  <= exp_mem[cur_a];
        rel_q  <= rel_mem[cur_a];
    end

    // control next values
    always_comb
    begin
        ct_next = ct_reg;
        if (cfg_we)
            ct_next = cfg_wdata;
        else if (cmd.op == htw_pkg::OP_N_RD)
            ct_next = ct_reg + 64'd1;

        active_next = active_reg;
        if (cmd.op == htw_pkg::OP_F_WR)
            active_next[cur_a] = 1'b1;
        else if (cmd.op == htw_pkg::OP_UL_WR || cmd.op == htw_pkg::OP_DEACT)
            active_next[cur_a] = 1'b0;

        clr_cnt_next = clr_cnt_reg;
        if (cmd.op == htw_pkg::OP_CLR)
            clr_cnt_next = clr_cnt_reg + SW'(1);

        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct_reg        <= '0;
            active_reg    <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ct_reg        <= ct_next;
            active_reg    <= active_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            id_reg   <= timer_id;
            now_reg  <= now;
            exp_reg  <= expire_time;
            cur_reg  <= LW'(timer_id);
        end
        case (cmd.op)
            htw_pkg::OP_UL_SRD:
            begin
                s_reg <= sid_q;
                p_reg <= prev_q;
                n_reg <= next_q;
            end
            htw_pkg::OP_F_D:     d_reg <= exp_reg - ct_reg;
            htw_pkg::OP_F_S:     s_reg <= pick;
            htw_pkg::OP_F_WR:    t_reg <= slot_tail;
            htw_pkg::OP_T_START: lvl_reg <= '0;
            htw_pkg::OP_C_RD:
            begin
                s_reg   <= c_slot;
                idx_reg <= c_idx;
            end
            htw_pkg::OP_C_NEXT:  lvl_reg <= lvl_reg + htw_pkg::LVL_W'(1);
            htw_pkg::OP_N_RD:    s_reg <= near_slot;
            htw_pkg::OP_C_DET, htw_pkg::OP_N_DET:
                cur_reg <= slot_head;
            htw_pkg::OP_C_NLD:
            begin
                nx_reg  <= next_q;
                exp_reg <= exp_q;
            end
            htw_pkg::OP_N_NLD:
            begin
                nx_reg  <= next_q;
                exp_reg <= reload_exp;
            end
            htw_pkg::OP_ADV:     cur_reg <= nx_reg;
            default:             ;
        endcase
        if (emit && cmd.op == htw_pkg::OP_EMIT_FIRE)
            cur_reg <= nx_reg;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            case (cmd.op)
                htw_pkg::OP_EMIT_DONE:
                begin
                    status_reg   <= htw_pkg::ST_DONE;
                    fired_id_reg <= id_reg;
                    last_reg     <= 1'b1;
                end
                htw_pkg::OP_EMIT_INACT:
                begin
                    status_reg   <= htw_pkg::ST_INACT;
                    fired_id_reg <= id_reg;
                    last_reg     <= 1'b1;
                end
                htw_pkg::OP_EMIT_NONE:
                begin
                    status_reg   <= htw_pkg::ST_NONE;
                    fired_id_reg <= id_reg;
                    last_reg     <= 1'b1;
                end
                default:
                begin
                    status_reg   <= htw_pkg::ST_FIRED;
                    fired_id_reg <= cur_a;
                    last_reg     <= (nx_reg == htw_pkg::NIL);
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign fired_id  = fired_id_reg;
    assign last      = last_reg;

    // status to the sequencer
    assign sts.kind        = kind_reg;
    assign sts.active      = active_reg[cur_a];
    assign sts.late        = (ct_reg > now_reg);
    assign sts.ct_low_zero = (ct_reg[htw_pkg::NEAR_BITS-1:0] == '0);
    assign sts.head_nil    = (slot_head == htw_pkg::NIL);
    assign sts.nx_nil      = (nx_reg == htw_pkg::NIL);
    assign sts.idx_zero    = (idx_reg == '0);
    assign sts.lvl_last    = (lvl_reg == htw_pkg::LVL_W'(htw_pkg::OUTER_LEVELS - 1));
    assign sts.per_rd      = rel_q[32];
    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.clr_last    = (clr_cnt_reg == SW'(htw_pkg::NSLOTS - 1));

endmodule

// ----- src/htw_chk.sv -----
// ----------------------------------------------------------------------------
// htw_chk - timer wheel port checks
// Port-level checks on result ordering and handshake, bound to the top.
// ----------------------------------------------------------------------------
module htw_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [5:0] fired_id,
    input logic       last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                    && $stable(fired_id) && $stable(last))
        else $error("result changed while stalled");

    // one item at a time: no transfer right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous one in progress");

    // only fired results can be followed by more of the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != htw_pkg::ST_FIRED |-> last)
        else $error("non-fire result not marked last");

endmodule

bind hierarchical_timer_wheel htw_chk u_htw_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item_in.valid),
    .in_ready  (item_in.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (result.status),
    .fired_id  (result.fired_id),
    .last      (result.last)
);

// ----- tb/sv/htw_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htw_tb_if - testbench side of the timer wheel channels
// The channel interfaces come with the RTL; this file holds the small
// record types that the timer wheel testbench passes between its processes.
// ----------------------------------------------------------------------------
package htw_tb_pkg;

    // one command item as queued for the driver
    typedef struct {
        logic [1:0]  kind;
        logic [5:0]  timer_id;
        logic [63:0] expire_time;
        logic [31:0] interval;
        logic        periodic;
        logic [63:0] now;
    } wheel_cmd_t;

    // one predicted result
    typedef struct {
        logic [1:0] status;
        logic [5:0] fired_id;
        logic       last;
    } wheel_result_t;

endpackage

// ----- tb/sv/hierarchical_timer_wheel_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_tb - self-checking bench for the timing wheel
// Feeds add, stop and tick items with random gaps, models the wheel's slot
// lists, cascading and reloads, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_tb;

    localparam int NO_LINK  = htw_pkg::MAX_TIMERS;
    localparam int OFF_SLOT = htw_pkg::NSLOTS;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [63:0] cfg_wdata;

    htw_in_if  item_in ();
    htw_out_if result ();

    hierarchical_timer_wheel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // wheel model state
    logic [63:0] wheel_time;
    int          head_of   [htw_pkg::NSLOTS];
    int          tail_of   [htw_pkg::NSLOTS];
    int          next_of   [htw_pkg::MAX_TIMERS];
    int          prev_of   [htw_pkg::MAX_TIMERS];
    logic [63:0] expiry_of [htw_pkg::MAX_TIMERS];
    logic [31:0] reload_of [htw_pkg::MAX_TIMERS];
    logic        repeat_of [htw_pkg::MAX_TIMERS];
    int          slot_of   [htw_pkg::MAX_TIMERS];

    htw_tb_pkg::wheel_cmd_t    pending_cmds[$];
    htw_tb_pkg::wheel_result_t awaited[$];
    int            errors;
    int            fired_count;
    int            items_sent;
    int            drv_gap;
    int            mon_gap;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int slot_in_level(int lvl, logic [63:0] t);
        int sh;
        sh = htw_pkg::NEAR_BITS + lvl * htw_pkg::LEVEL_BITS;
        return htw_pkg::NEAR_SIZE + lvl * htw_pkg::LEVEL_SIZE
             + int'((t >> sh) & (htw_pkg::LEVEL_SIZE - 1));
    endfunction

    // slot choice from distance to the wheel time
    function automatic int choose_slot(logic [63:0] xp);
        logic [63:0] d;
        d = xp - wheel_time;
        if (d < htw_pkg::NEAR_SIZE)
            return int'(xp[htw_pkg::NEAR_BITS-1:0]);
        for (int l = 0; l + 1 < htw_pkg::OUTER_LEVELS; l++)
            if (d < (64'd1 << (htw_pkg::NEAR_BITS + (l + 1) * htw_pkg::LEVEL_BITS)))
                return slot_in_level(l, xp);
        if (d[63])
            return int'(wheel_time[htw_pkg::NEAR_BITS-1:0]);
        if (d > htw_pkg::CLAMP_SPAN)
            xp = wheel_time + htw_pkg::CLAMP_SPAN;
        return slot_in_level(htw_pkg::OUTER_LEVELS - 1, xp);
    endfunction

    function automatic void append_timer(int id);
        int s;
        int t;
        s = choose_slot(expiry_of[id]);
        t = tail_of[s];
        slot_of[id] = s;
        next_of[id] = NO_LINK;
        prev_of[id] = t;
        if (t == NO_LINK)
            head_of[s] = id;
        else
            next_of[t] = id;
        tail_of[s] = id;
    endfunction

    function automatic void remove_timer(int id);
        int s;
        int p;
        int n;
        s = slot_of[id];
        p = prev_of[id];
        n = next_of[id];
        if (s >= OFF_SLOT)
            return;
        if (p == NO_LINK) head_of[s] = n; else next_of[p] = n;
        if (n == NO_LINK) tail_of[s] = p; else prev_of[n] = p;
        slot_of[id] = OFF_SLOT;
    endfunction

    function automatic int take_list(int s);
        int h;
        h = head_of[s];
        head_of[s] = NO_LINK;
        tail_of[s] = NO_LINK;
        return h;
    endfunction

    function automatic void reset_wheel();
        wheel_time = '0;
        for (int i = 0; i < htw_pkg::NSLOTS; i++)
        begin
            head_of[i] = NO_LINK;
            tail_of[i] = NO_LINK;
        end
        for (int i = 0; i < htw_pkg::MAX_TIMERS; i++)
        begin
            next_of[i] = 0;
            prev_of[i] = 0;
            expiry_of[i] = '0;
            reload_of[i] = '0;
            repeat_of[i] = 1'b0;
            slot_of[i] = OFF_SLOT;
        end
    endfunction

    // append one item to the driver queue
    function automatic void queue_cmd(htw_tb_pkg::wheel_cmd_t c);
        pending_cmds = {pending_cmds, c};
    endfunction

    function automatic void push_result(logic [1:0] st, int id, logic lst);
        htw_tb_pkg::wheel_result_t r;
        r.status = st;
        r.fired_id = 6'(id);
        r.last = lst;
        awaited = {awaited, r};
    endfunction

    // expected results of one accepted item
    function automatic void predict_item(htw_tb_pkg::wheel_cmd_t c);
        int id;
        int nidx;
        int cur;
        int nx;
        int n;
        int idx;
        id = int'(c.timer_id);
        n = 0;
        if (c.kind == htw_pkg::K_ADD)
        begin
            remove_timer(id);
            expiry_of[id] = c.expire_time;
            reload_of[id] = c.interval;
            repeat_of[id] = c.periodic;
            append_timer(id);
            push_result(htw_pkg::ST_DONE, id, 1'b1);
        end
        else if (c.kind == htw_pkg::K_STOP)
        begin
            if (slot_of[id] < OFF_SLOT)
            begin
                remove_timer(id);
                push_result(htw_pkg::ST_DONE, id, 1'b1);
            end
            else
                push_result(htw_pkg::ST_INACT, id, 1'b1);
        end
        else if (c.kind == htw_pkg::K_TICK)
        begin
            if (wheel_time > c.now)
            begin
                push_result(htw_pkg::ST_NONE, id, 1'b1);
                return;
            end
            nidx = int'(wheel_time[htw_pkg::NEAR_BITS-1:0]);
            // cascade outer levels on near wrap
            if (nidx == 0)
                for (int l = 0; l < htw_pkg::OUTER_LEVELS; l++)
                begin
                    idx = int'((wheel_time >> (htw_pkg::NEAR_BITS + l * htw_pkg::LEVEL_BITS))
                               & (htw_pkg::LEVEL_SIZE - 1));
                    cur = take_list(htw_pkg::NEAR_SIZE + l * htw_pkg::LEVEL_SIZE + idx);
                    while (cur != NO_LINK)
                    begin
                        nx = next_of[cur];
                        append_timer(cur);
                        cur = nx;
                    end
                    if (idx != 0)
                        break;
                end
            wheel_time = wheel_time + 64'd1;
            cur = take_list(nidx);
            while (cur != NO_LINK && n < htw_pkg::MAX_TIMERS)
            begin
                nx = next_of[cur];
                if (repeat_of[cur])
                begin
                    expiry_of[cur] = c.now + 64'(reload_of[cur]);
                    append_timer(cur);
                end
                else
                    slot_of[cur] = OFF_SLOT;
                if (n > 0)
                    awaited[$].last = 1'b0;
                push_result(htw_pkg::ST_FIRED, cur, 1'b1);
                n++;
                cur = nx;
            end
            fired_count += n;
            if (n == 0)
                push_result(htw_pkg::ST_NONE, id, 1'b1);
        end
    endfunction

    function automatic htw_tb_pkg::wheel_cmd_t make_cmd(logic [1:0] k, int id,
                                                        logic [63:0] xp, logic [31:0] iv,
                                                        logic per, logic [63:0] nw);
        htw_tb_pkg::wheel_cmd_t c;
        c.kind = k;
        c.timer_id = 6'(id);
        c.expire_time = xp;
        c.interval = iv;
        c.periodic = per;
        c.now = nw;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_in.valid <= 1'b0;
            item_in.kind <= htw_pkg::K_ADD;
            item_in.timer_id <= '0;
            item_in.expire_time <= '0;
            item_in.interval <= '0;
            item_in.periodic <= 1'b0;
            item_in.now <= '0;
            drv_gap <= 0;
        end
        else
        begin
            if (item_in.valid && item_in.ready)
            begin
                predict_item(pending_cmds.pop_front());
                items_sent <= items_sent + 1;
            end
            if (item_in.valid && !item_in.ready)
                ;
            else if (drv_gap > 0)
            begin
                item_in.valid <= 1'b0;
                drv_gap <= drv_gap - 1;
            end
            else if (pending_cmds.size() != 0)
            begin
                item_in.valid <= 1'b1;
                item_in.kind <= pending_cmds[0].kind;
                item_in.timer_id <= pending_cmds[0].timer_id;
                item_in.expire_time <= pending_cmds[0].expire_time;
                item_in.interval <= pending_cmds[0].interval;
                item_in.periodic <= pending_cmds[0].periodic;
                item_in.now <= pending_cmds[0].now;
                drv_gap <= rand_gap();
            end
            else
                item_in.valid <= 1'b0;
        end
    end

    // monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            mon_gap <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%t unexpected result: status %0d id %0d last %0b",
                             $realtime, result.status, result.fired_id, result.last);
                    errors <= errors + 1;
                end
                else
                begin
                    if (awaited[0].status !== result.status
                        || awaited[0].fired_id !== result.fired_id
                        || awaited[0].last !== result.last)
                    begin
                        $display("%t mismatch: exp status %0d id %0d last %0b, got %0d %0d %0b",
                                 $realtime, awaited[0].status, awaited[0].fired_id,
                                 awaited[0].last, result.status, result.fired_id, result.last);
                        errors <= errors + 1;
                    end
                    void'(awaited.pop_front());
                end
            end
            if (mon_gap > 0)
            begin
                result.ready <= 1'b0;
                mon_gap <= mon_gap - 1;
            end
            else
            begin
                result.ready <= 1'b1;
                mon_gap <= ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
            end
        end
    end

    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || item_in.valid || awaited.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_start(logic [63:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        wheel_time = v;
    endtask

    // one phase of random traffic around a base time
    task automatic random_phase(int count, logic [63:0] base);
        logic [63:0] tnow;
        int r;
        logic [63:0] xp;
        tnow = base;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                case ($urandom_range(0, 5))
                    0: xp = tnow + $urandom_range(0, 255);
                    1: xp = tnow + $urandom_range(256, 20000);
                    2: xp = tnow + $urandom_range(0, 3);
                    3: xp = rand64();
                    4: xp = tnow - $urandom_range(1, 50);
                    default: xp = tnow + {$urandom_range(0, 3), $urandom()};
                endcase
                queue_cmd(make_cmd(htw_pkg::K_ADD, $urandom_range(0, 63), xp,
                    ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 300),
                    1'($urandom_range(0, 1)), rand64()));
            end
            else if (r < 45)
                queue_cmd(make_cmd(htw_pkg::K_STOP, $urandom_range(0, 63), rand64(),
                    $urandom(), 1'($urandom_range(0, 1)), rand64()));
            else if (r < 97)
            begin
                // ticks mostly advance by up to two steps; sometimes lag by five
                if ($urandom_range(0, 9) == 0)
                    tnow = tnow - 5;
                else
                    tnow = tnow + $urandom_range(0, 2);
                queue_cmd(make_cmd(htw_pkg::K_TICK, $urandom_range(0, 63), rand64(),
                    $urandom(), 1'($urandom_range(0, 1)), tnow));
            end
            else
                queue_cmd(make_cmd(htw_pkg::K_TICK, $urandom_range(0, 63), rand64(),
                    $urandom(), 1'($urandom_range(0, 1)), '1));
        end
    endtask

    // stimulus
    initial
    begin
        reset_wheel();
        errors = 0;
        fired_count = 0;
        items_sent = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, clamp, past expiry, stop cases, tick cases
        queue_cmd(make_cmd(htw_pkg::K_TICK, 63, '0, '0, 1'b0, '0));
        queue_cmd(make_cmd(htw_pkg::K_ADD, 0, 64'd1, 32'd2, 1'b1, '1));
        queue_cmd(make_cmd(htw_pkg::K_ADD, 63, '1, '1, 1'b0, '0));
        queue_cmd(make_cmd(htw_pkg::K_ADD, 5, 64'h0000_0002_0000_0000, '0, 1'b0, '0));
        queue_cmd(make_cmd(htw_pkg::K_ADD, 6, 64'd300, '0, 1'b0, '0));
        queue_cmd(make_cmd(htw_pkg::K_ADD, 7, 64'd1, '0, 1'b0, '0));
        queue_cmd(make_cmd(htw_pkg::K_ADD, 6, 64'd1, '0, 1'b0, '0));
        queue_cmd(make_cmd(htw_pkg::K_STOP, 5, '0, '0, 1'b0, '0));
        queue_cmd(make_cmd(htw_pkg::K_STOP, 5, '1, '1, 1'b1, '1));
        queue_cmd(make_cmd(htw_pkg::K_STOP, 42, '0, '0, 1'b0, '0));
        queue_cmd(make_cmd(htw_pkg::K_TICK, 9, '0, '0, 1'b0, '0));
        queue_cmd(make_cmd(htw_pkg::K_TICK, 10, '0, '0, 1'b0, 64'd1));
        queue_cmd(make_cmd(htw_pkg::K_TICK, 11, '0, '0, 1'b0, 64'd0));
        queue_cmd(make_cmd(htw_pkg::K_TICK, 12, '0, '0, 1'b0, 64'd2));
        queue_cmd(make_cmd(htw_pkg::K_TICK, 13, '0, '0, 1'b0, 64'd3));
        queue_cmd(make_cmd(2'd3, 14, '1, '1, 1'b1, '1));
        wait_quiet();

        // start near the top of the range, including past-the-wrap expiry
        write_start('1 - 64'd2);
        queue_cmd(make_cmd(htw_pkg::K_ADD, 1, 64'd0, 32'd1, 1'b1, '0));
        queue_cmd(make_cmd(htw_pkg::K_ADD, 2, '1, '0, 1'b0, '0));
        for (int i = 0; i < 5; i++)
            queue_cmd(make_cmd(htw_pkg::K_TICK, i, '0, '0, 1'b0, '1));
        wait_quiet();

        // just before a cascade boundary, then mid-range and zero
        write_start(64'd16_000);
        random_phase(110, 64'd16_000);
        wait_quiet();
        write_start(64'h0000_0001_2345_0000);
        random_phase(100, 64'h0000_0001_2345_0000);
        wait_quiet();
        write_start('0);
        random_phase(80, '0);
        wait_quiet();

        $display("%0d items sent, %0d timer firings checked, start time swept 0 to max",
                 items_sent, fired_count);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // overall limit
    initial
    begin
        #100ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
